/* hdl/rhp_pkg.sv */
// ----------------------------------------------------------------------------
// rhp_pkg: shared types and constants of the rgb to hsv pixel converter
// channel widths, hue scale constants, sector codes and divider sideband
// ----------------------------------------------------------------------------
package rhp_pkg;

	localparam int CH_W      = 8;
	localparam int HUE_W     = 15;
	localparam int SAT_W     = 17;
	localparam int SAT_FRAC  = 16;
	localparam int QUO_W     = 17;
	localparam int DIV_LANES = 2;
	localparam int DIV_NW    = QUO_W + CH_W;
	localparam int PROD_W    = 20;
	localparam int SUM_W     = 16;
	localparam int RATIO_W   = 13;

	localparam int LANE_SAT = 0;
	localparam int LANE_HUE = 1;

	localparam int HUE_SIXTY = 3840;
	localparam int HUE_ONE20 = 7680;
	localparam int HUE_TWO40 = 15360;
	localparam int HUE_FULL  = 23040;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sec_t;

	typedef struct packed {
		sec_t            sec;
		logic            neg;
		logic            grey;
		logic [CH_W-1:0] value;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

endpackage

/* hdl/rgb_to_hsv_pixel.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel: streaming rgb to hsv pixel converter
//
// input channel pixel_valid / pixel_ready carries one pixel word as
// blue_in, green_in, red_in. output channel hsv_valid / hsv_ready carries
// hue_out (1/64 degree, 0..23039), saturation_out (65536 means 1.0) and
// value_out (largest channel). grey and black pixels give hue 0.
// the pipeline has one stage for max/min and sector, one for the hue scale
// product, 17 stages of the pipelined divider (one quotient bit each,
// saturation and hue lanes side by side) and one output stage for the hue
// sum and wrap.
// throughput is one pixel word per cycle while hsv_ready stays high.
// reset clears every stage valid bit; no pixel is in flight after it.
// when hsv_ready is low the output word holds, and each stage keeps taking
// words while an empty stage lies ahead of it, so pixel_ready drops only
// once the pipeline is full.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  logic [rhp_pkg::CH_W-1:0]    blue_in,
	input  logic [rhp_pkg::CH_W-1:0]    green_in,
	input  logic [rhp_pkg::CH_W-1:0]    red_in,
	output logic                        hsv_valid,
	input  logic                        hsv_ready,
	output logic [rhp_pkg::HUE_W-1:0]   hue_out,
	output logic [rhp_pkg::SAT_W-1:0]   saturation_out,
	output logic [rhp_pkg::CH_W-1:0]    value_out
);

	localparam int CW = rhp_pkg::CH_W;
	localparam int QW = rhp_pkg::QUO_W;
	localparam int NW = rhp_pkg::DIV_NW;
	localparam int NL = rhp_pkg::DIV_LANES;
	localparam int SW = rhp_pkg::SUM_W;

	// stage 1 signals
	logic [CW-1:0]       mx, mn;
	rhp_pkg::sec_t       sec;
	logic signed [CW:0]  diff, ndiff;
	logic [CW-1:0]       mag;

	logic                v_s1, v_s2, v_s20;
	logic                rdy_s1, rdy_s2, rdy_s20;
	logic [CW-1:0]       value_s1, delta_s1, mag_s1;
	rhp_pkg::sec_t       sec_s1, sec_s2;
	logic                neg_s1, neg_s2;
	logic [CW-1:0]       value_s2, delta_s2;
	logic [rhp_pkg::PROD_W-1:0] prod_s2;

	logic                        div_in_ready, div_out_valid;
	logic [NL-1:0][NW-1:0]       div_num;
	logic [NL-1:0][CW-1:0]       div_den;
	logic [NL-1:0][QW-1:0]       div_quo;
	logic [NL-1:0][CW-1:0]       div_rem;
	rhp_pkg::side_t              side_in, side_out;
	logic [rhp_pkg::SIDE_W-1:0]  side_out_bits;

	logic [rhp_pkg::RATIO_W-1:0] ratio_mag;
	logic signed [SW-1:0]        ratio, base, sum, hue_sum;
	logic [rhp_pkg::HUE_W-1:0]   hue_nxt;
	logic [rhp_pkg::SAT_W-1:0]   sat_nxt;

	logic [rhp_pkg::HUE_W-1:0]   hue_s20;
	logic [rhp_pkg::SAT_W-1:0]   sat_s20;
	logic [CW-1:0]               value_s20;

	// ready chain
	assign rdy_s20     = !v_s20 || hsv_ready;
	assign rdy_s2      = !v_s2 || div_in_ready;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign pixel_ready = rdy_s1;

	// max, min and sector, red over green over blue
	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx) mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn) mn = blue_in;
		if (red_in == mx) begin
			sec  = rhp_pkg::SEC_RED;
			diff = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
		end else if (green_in == mx) begin
			sec  = rhp_pkg::SEC_GREEN;
			diff = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
		end else begin
			sec  = rhp_pkg::SEC_BLUE;
			diff = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
		end
		ndiff = -diff;
		mag   = diff[CW] ? ndiff[CW-1:0] : diff[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s20 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pixel_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s20) v_s20 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel_valid) begin
			value_s1 <= mx;
			delta_s1 <= mx - mn;
			sec_s1   <= sec;
			neg_s1   <= diff[CW];
			mag_s1   <= mag;
		end
		if (rdy_s2 && v_s1) begin
			value_s2 <= value_s1;
			delta_s2 <= delta_s1;
			sec_s2   <= sec_s1;
			neg_s2   <= neg_s1;
			prod_s2  <= rhp_pkg::PROD_W'(mag_s1) * rhp_pkg::PROD_W'(rhp_pkg::HUE_SIXTY);
		end
		if (rdy_s20 && div_out_valid) begin
			hue_s20   <= hue_nxt;
			sat_s20   <= sat_nxt;
			value_s20 <= side_out.value;
		end
	end

	// divider lanes: delta*65536/max and 3840*|difference|/delta
	always_comb begin
		div_num[rhp_pkg::LANE_SAT] = NW'({delta_s2, {rhp_pkg::SAT_FRAC{1'b0}}});
		div_den[rhp_pkg::LANE_SAT] = value_s2;
		div_num[rhp_pkg::LANE_HUE] = NW'(prod_s2);
		div_den[rhp_pkg::LANE_HUE] = delta_s2;
		side_in.sec   = sec_s2;
		side_in.neg   = neg_s2;
		side_in.grey  = (delta_s2 == '0);
		side_in.value = value_s2;
	end

	rhp_div #(
		.QW  (QW),
		.DVW (CW),
		.NL  (NL),
		.SBW (rhp_pkg::SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.num       (div_num),
		.den       (div_den),
		.side_in   (side_in),
		.out_valid (div_out_valid),
		.out_ready (rdy_s20),
		.quo       (div_quo),
		.rem       (div_rem),
		.side_out  (side_out_bits)
	);

	assign side_out = rhp_pkg::side_t'(side_out_bits);

	// hue: sector base plus floored ratio, wrapped into one turn, zero for grey; saturation zero for black
	always_comb begin
		ratio_mag = rhp_pkg::RATIO_W'(div_quo[rhp_pkg::LANE_HUE])
			+ rhp_pkg::RATIO_W'(side_out.neg && (div_rem[rhp_pkg::LANE_HUE] != '0));
		ratio = side_out.neg ? -$signed(SW'(ratio_mag)) : $signed(SW'(ratio_mag));
		unique case (side_out.sec)
			rhp_pkg::SEC_RED:   base = '0;
			rhp_pkg::SEC_GREEN: base = SW'(rhp_pkg::HUE_ONE20);
			rhp_pkg::SEC_BLUE:  base = SW'(rhp_pkg::HUE_TWO40);
			default:            base = '0;
		endcase
		sum     = base + ratio;
		hue_sum = sum[SW-1] ? sum + SW'(rhp_pkg::HUE_FULL) : sum;
		hue_nxt = side_out.grey ? '0 : hue_sum[rhp_pkg::HUE_W-1:0];
		sat_nxt = (side_out.value == '0) ? '0 : div_quo[rhp_pkg::LANE_SAT];
	end

	assign hsv_valid      = v_s20;
	assign hue_out        = hue_s20;
	assign saturation_out = sat_s20;
	assign value_out      = value_s20;

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue_out < rhp_pkg::HUE_W'(rhp_pkg::HUE_FULL))
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> saturation_out <= rhp_pkg::SAT_W'(1 << rhp_pkg::SAT_FRAC))
		else $error("saturation above one");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && value_out == '0 |-> saturation_out == '0 && hue_out == '0)
		else $error("black word with nonzero hue or saturation");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation_out == '0 |-> hue_out == '0)
		else $error("grey word with nonzero hue");
`endif

endmodule

/* hdl/rhp_div.sv */
// ----------------------------------------------------------------------------
// rhp_div: pipelined restoring divider, several lanes in lockstep
// one quotient bit per stage, valid bits per stage, stalls collapse bubbles
// ----------------------------------------------------------------------------
module rhp_div #(
	parameter int QW  = rhp_pkg::QUO_W,
	parameter int DVW = rhp_pkg::CH_W,
	parameter int NL  = rhp_pkg::DIV_LANES,
	parameter int SBW = rhp_pkg::SIDE_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [NL-1:0][QW+DVW-1:0]     num,
	input  logic [NL-1:0][DVW-1:0]        den,
	input  logic [SBW-1:0]                side_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [NL-1:0][QW-1:0]         quo,
	output logic [NL-1:0][DVW-1:0]        rem,
	output logic [SBW-1:0]                side_out
);

	logic [QW:1]                  v_s;
	logic [NL-1:0][DVW-1:0]       rem_s  [1:QW];
	logic [NL-1:0][QW-1:0]        qn_s   [1:QW];
	logic [NL-1:0][DVW-1:0]       den_s  [1:QW];
	logic [SBW-1:0]               sb_s   [1:QW];

	logic [QW:1]                  v_src;
	logic [NL-1:0][DVW-1:0]       rem_src [1:QW];
	logic [NL-1:0][QW-1:0]        qn_src  [1:QW];
	logic [NL-1:0][DVW-1:0]       den_src [1:QW];
	logic [SBW-1:0]               sb_src  [1:QW];

	logic [NL-1:0][DVW-1:0]       rem_nxt [1:QW];
	logic [NL-1:0][QW-1:0]        qn_nxt  [1:QW];

	logic [QW+1:1]                rdy;

	// ready chain, a stage moves when it is empty or the next one moves
	always_comb begin
		rdy[QW+1] = out_ready;
		for (int k = QW; k >= 1; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		v_src[1] = in_valid;
		sb_src[1] = side_in;
		for (int l = 0; l < NL; l++) begin
			rem_src[1][l] = num[l][QW+DVW-1:QW];
			qn_src[1][l]  = num[l][QW-1:0];
			den_src[1][l] = den[l];
		end
		for (int k = 2; k <= QW; k++) begin
			v_src[k]   = v_s[k-1];
			sb_src[k]  = sb_s[k-1];
			rem_src[k] = rem_s[k-1];
			qn_src[k]  = qn_s[k-1];
			den_src[k] = den_s[k-1];
		end
	end

	// one trial subtract per lane and stage
	always_comb begin
		logic [DVW:0] trial;
		logic [DVW:0] diff;
		logic         ge;
		for (int k = 1; k <= QW; k++) begin
			for (int l = 0; l < NL; l++) begin
				trial = {rem_src[k][l], qn_src[k][l][QW-1]};
				diff  = trial - {1'b0, den_src[k][l]};
				ge    = trial >= {1'b0, den_src[k][l]};
				rem_nxt[k][l] = ge ? diff[DVW-1:0] : trial[DVW-1:0];
				qn_nxt[k][l]  = {qn_src[k][l][QW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 1; k <= QW; k++) begin
				if (rdy[k]) begin
					v_s[k] <= v_src[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= QW; k++) begin
			if (rdy[k] && v_src[k]) begin
				rem_s[k] <= rem_nxt[k];
				qn_s[k]  <= qn_nxt[k];
				den_s[k] <= den_src[k];
				sb_s[k]  <= sb_src[k];
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = v_s[QW];
	assign quo       = qn_s[QW];
	assign rem       = rem_s[QW];
	assign side_out  = sb_s[QW];

endmodule
